### sv/ssr_pkg.sv
// ssr_pkg: shared types and constants for the streaming substring replace block
// no dependencies; imported by every module of the block
`default_nettype none

package ssr_pkg;

   localparam int CHAR_W    = 8;
   localparam int LEN_W     = 4;
   localparam int TEXT_W    = 64;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SEARCH_TEXT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEARCH_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACE_TEXT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACE_LENGTH = 2'd3;

   // one result beat
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              valid;
      logic              last;
   } res_type;

   // control broadcast to every window cell
   typedef struct packed {
      logic              step;
      logic              shift;
      logic [CHAR_W-1:0] ch;
   } cell_ctl_type;

endpackage

`default_nettype wire

### sv/stream_substring_replace.sv
// stream_substring_replace: top level, window cell chain, result queue, registers
// depends on ssr_pkg, ssr_cell, ssr_outq
`default_nettype none

// Streaming find-and-replace on a byte stream. Each input beat carries one
// character; every leftmost, non-overlapping occurrence of the search string
// is replaced by the replacement string, and the end of the text (tlast) flushes
// the pending window and marks the final result beat. A text whose last beat
// yields nothing ends with a bare marker beat (tuser 0, tdata 0, tlast 1).
// Rate: a byte is taken in the cycle it arrives if the chain has room, and
// its results are registered into the chain. A byte that yields n result beats
// holds the input while the chain drains; the chain takes new beats when at most
// one beat waits, so one byte per cycle is sustained when each byte yields at
// most one beat and no result beat stalls. Write the registers only while idle;
// writing search_length drops the pending bytes. No clearing pass follows reset.
module stream_substring_replace
   import ssr_pkg::*;
#(
   parameter int SEARCH_MAX  = 8,
   parameter int REPLACE_MAX = 8
) (
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   // request stream
   input  wire  logic                 req_tvalid,
   output logic                       req_tready,
   input  wire  logic [CHAR_W-1:0]    req_tdata,   // [7:0] in_char
   input  wire  logic                 req_tlast,   // in_last
   // response stream
   output logic                       rsp_tvalid,
   input  wire  logic                 rsp_tready,
   output logic [CHAR_W-1:0]          rsp_tdata,   // [7:0] out_char
   output logic                       rsp_tuser,   // [0] char_valid
   output logic                       rsp_tlast,   // out_last
   // register writes
   input  wire  logic                 csr_we,
   input  wire  logic [CSR_IDX_W-1:0] csr_index,
   input  wire  logic [TEXT_W-1:0]    csr_wdata
);

   localparam int RES_MAX = (SEARCH_MAX > REPLACE_MAX) ? SEARCH_MAX : REPLACE_MAX;
   localparam int DEPTH   = RES_MAX + 1;

   logic [TEXT_W-1:0] search_text_ff;
   logic [LEN_W-1:0]  search_length_ff;
   logic [TEXT_W-1:0] replace_text_ff;
   logic [LEN_W-1:0]  replace_length_ff;
   logic [LEN_W-1:0]  pc_ff;
   logic [LEN_W-1:0]  pc_in;

   logic              accept;
   logic              pop;
   logic [LEN_W-1:0]  slen;
   logic [LEN_W-1:0]  rlen;
   logic [LEN_W-1:0]  pc_app;
   logic              full;
   logic              hit;
   logic              match;
   logic [LEN_W-1:0]  n_res;
   logic              marker;
   logic [LEN_W-1:0]  push_n;
   logic              room;
   logic              nonempty;
   res_type           head;
   res_type           ent [DEPTH-1];
   cell_ctl_type      ctl;
   logic [CHAR_W-1:0] wcur [SEARCH_MAX];
   logic [SEARCH_MAX-1:0] eq;

   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = room;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         search_text_ff    <= '0;
         search_length_ff  <= LEN_W'(1);
         replace_text_ff   <= '0;
         replace_length_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SEARCH_TEXT:    search_text_ff    <= csr_wdata;
            REG_SEARCH_LENGTH:  search_length_ff  <= csr_wdata[LEN_W-1:0];
            REG_REPLACE_TEXT:   replace_text_ff   <= csr_wdata;
            REG_REPLACE_LENGTH: replace_length_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // effective lengths, clamped to the build limits
   always_comb begin
      if (search_length_ff == '0) begin
         slen = LEN_W'(1);
      end else if (search_length_ff > LEN_W'(SEARCH_MAX)) begin
         slen = LEN_W'(SEARCH_MAX);
      end else begin
         slen = search_length_ff;
      end
      if (replace_length_ff > LEN_W'(REPLACE_MAX)) begin
         rlen = LEN_W'(REPLACE_MAX);
      end else begin
         rlen = replace_length_ff;
      end
   end

   // window after the new byte is appended
   assign pc_app = pc_ff + LEN_W'(1);
   assign full   = (pc_app >= slen);

   always_comb begin
      hit = 1'b1;
      for (int i = 0; i < SEARCH_MAX; i++) begin
         if (LEN_W'(i) < slen && !eq[i]) begin
            hit = 1'b0;
         end
      end
   end
   assign match = full && hit;

   // cell control: slide the window on a full window without a match, except on the last byte
   assign ctl.step  = accept;
   assign ctl.shift = full && !match && !req_tlast;
   assign ctl.ch    = req_tdata;

   // chain of window cells
   for (genvar i = 0; i < SEARCH_MAX; i++) begin : g_win
      logic [CHAR_W-1:0] nbr;
      if (i + 1 < SEARCH_MAX) begin : g_mid
         assign nbr = wcur[(i + 1 < SEARCH_MAX) ? i + 1 : i];
      end else begin : g_end
         assign nbr = '0;
      end
      ssr_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .load    (pc_ff == LEN_W'(i)),
         .nbr_cur (nbr),
         .want    (search_text_ff[CHAR_W*i +: CHAR_W]),
         .cur     (wcur[i]),
         .eq      (eq[i])
      );
   end

   // number of result beats for this byte
   always_comb begin
      if (match) begin
         n_res = rlen;
      end else if (req_tlast) begin
         n_res = pc_app;
      end else begin
         n_res = {{(LEN_W-1){1'b0}}, full};
      end
   end
   assign marker = req_tlast && (n_res == '0);
   assign push_n = marker ? LEN_W'(1) : n_res;

   // result beats: replacement bytes, window bytes from the oldest, or the bare marker
   for (genvar j = 0; j < DEPTH - 1; j++) begin : g_res
      logic [CHAR_W-1:0] rep_b;
      logic [CHAR_W-1:0] win_b;
      if (j < REPLACE_MAX) begin : g_rep
         assign rep_b = replace_text_ff[CHAR_W*j +: CHAR_W];
      end else begin : g_norep
         assign rep_b = '0;
      end
      if (j < SEARCH_MAX) begin : g_win_b
         assign win_b = wcur[(j < SEARCH_MAX) ? j : 0];
      end else begin : g_nowin
         assign win_b = '0;
      end
      always_comb begin
         if (marker) begin
            ent[j].ch    = '0;
            ent[j].valid = 1'b0;
         end else begin
            ent[j].ch    = match ? rep_b : win_b;
            ent[j].valid = 1'b1;
         end
         ent[j].last = req_tlast && (LEN_W'(j + 1) == push_n);
      end
   end

   // pending count
   always_comb begin
      pc_in = pc_ff;
      if (accept) begin
         if (match || req_tlast) begin
            pc_in = '0;
         end else if (full) begin
            pc_in = pc_ff;
         end else begin
            pc_in = pc_app;
         end
      end
      if (csr_we && csr_index == REG_SEARCH_LENGTH) begin
         pc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // result chain
   ssr_outq #(
      .DEPTH (DEPTH)
   ) u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_n   (push_n),
      .push_ent (ent),
      .pop      (pop),
      .head     (head),
      .nonempty (nonempty),
      .room     (room)
   );

   assign rsp_tvalid = nonempty;
   assign rsp_tdata  = head.ch;
   assign rsp_tuser  = head.valid;
   assign rsp_tlast  = head.last;

endmodule

`default_nettype wire

### sv/ssr_cell.sv
// ssr_cell: one byte of the pending window with its search-byte comparator
// depends on ssr_pkg
`default_nettype none

module ssr_cell
   import ssr_pkg::*;
(
   input  wire  logic              clock,
   input  wire  cell_ctl_type      ctl,
   input  wire  logic              load,
   input  wire  logic [CHAR_W-1:0] nbr_cur,
   input  wire  logic [CHAR_W-1:0] want,
   output logic [CHAR_W-1:0]       cur,
   output logic                    eq
);

   logic [CHAR_W-1:0] byte_ff;
   logic [CHAR_W-1:0] byte_in;

   // window content with the incoming byte appended at this slot
   assign cur = load ? ctl.ch : byte_ff;
   assign eq  = (cur == want);

   // take the neighbor's byte when the window slides
   assign byte_in = ctl.shift ? nbr_cur : cur;

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         byte_ff <= byte_in;
      end
   end

endmodule

`default_nettype wire

### sv/ssr_outq.sv
// ssr_outq: shifting chain of result cells feeding the response stream
// depends on ssr_pkg
`default_nettype none

module ssr_outq
   import ssr_pkg::*;
#(
   parameter int DEPTH = 9
) (
   input  wire  logic             clock,
   input  wire  logic             reset,
   input  wire  logic             push,
   input  wire  logic [LEN_W-1:0] push_n,
   input  wire  res_type          push_ent [DEPTH-1],
   input  wire  logic             pop,
   output res_type                head,
   output logic                   nonempty,
   output logic                   room
);

   localparam int CW = $clog2(DEPTH + 1);

   res_type         q_ff [DEPTH];
   res_type         q_in [DEPTH];
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            base_one;

   assign head     = q_ff[0];
   assign nonempty = (count_ff != '0);
   assign room     = (count_ff <= CW'(1));

   // new beats land behind the head when it stays
   assign base_one = nonempty && !pop;

   // per-cell next value: new beat, neighbor on pop, or hold
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      always_comb begin
         if (pop && k + 1 < DEPTH) begin
            q_in[k] = q_ff[(k + 1 < DEPTH) ? k + 1 : k];
         end else begin
            q_in[k] = q_ff[k];
         end
         if (push && !base_one && k < DEPTH - 1 && CW'(k) < CW'(push_n)) begin
            q_in[k] = push_ent[(k < DEPTH - 1) ? k : 0];
         end
         if (push && base_one && k >= 1 && CW'(k - 1) < CW'(push_n)) begin
            q_in[k] = push_ent[(k >= 1) ? k - 1 : 0];
         end
      end

      always_ff @(posedge clock) begin
         q_ff[k] <= q_in[k];
      end
   end

   // occupancy
   assign count_in = count_ff - CW'(pop) + (push ? CW'(push_n) : CW'(0));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### sv/ssr_checker.sv
// ssr_checker: port-level checks for stream_substring_replace, with its bind
// depends on ssr_pkg and the stream_substring_replace top level
`default_nettype none

module ssr_checker
   import ssr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tready,
   input  wire logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic [CHAR_W-1:0] rsp_tdata,
   input  wire logic              rsp_tuser,
   input  wire logic              rsp_tlast
);

   // a stalled response beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response beat dropped while stalled");

   // a stalled response payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("response payload changed while stalled");

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result chain not empty after reset");

   // a beat without a character is the bare end marker
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("bare beat that is not an end marker");

   // with no result waiting the input is open
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result chain");

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### dv/tb.sv
// tb: self-checking bench for stream_substring_replace, find-and-replace on a byte stream
// depends on ssr_pkg and the block's rtl; a built-in rewrite predictor checks every
// result beat while both stream sides idle and stall at random
module tb
   import ssr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES   = 60;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_CHARS  = 450;

   typedef logic [CHAR_W-1:0] char_seq_type [$];

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [CHAR_W-1:0]    req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [CHAR_W-1:0]    rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [TEXT_W-1:0]    csr_wdata  = '0;

   // predictor copy of the registers and the pending window
   logic [TEXT_W-1:0] cfg_search      = '0;
   logic [LEN_W-1:0]  cfg_search_len  = 4'd1;
   logic [TEXT_W-1:0] cfg_replace     = '0;
   logic [LEN_W-1:0]  cfg_replace_len = '0;
   logic [CHAR_W-1:0] window [8];
   int unsigned       window_fill = 0;

   // rewritten text still owed by the block, oldest beat first
   res_type rewritten_q [$];

   int mismatches   = 0;
   int chars_sent   = 0;
   bit gaps_on      = 1'b1;
   bit hold_request = 1'b0;
   int hold_left    = 0;
   int stall_left   = 0;

   stream_substring_replace DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // effective search length: zero acts as one, above eight saturates
   function automatic int unsigned search_span();
      if (cfg_search_len == 0) return 1;
      if (cfg_search_len > 8) return 8;
      return cfg_search_len;
   endfunction

   function automatic void expect_beat(input logic [CHAR_W-1:0] ch, input logic valid);
      res_type beat;
      beat.ch    = ch;
      beat.valid = valid;
      beat.last  = 1'b0;
      rewritten_q.push_back(beat);
   endfunction

   // one accepted byte: match or shift the window, flush on the last byte
   function automatic void predict_rewrite(input logic [CHAR_W-1:0] ch, input logic last);
      int unsigned span, repl, i, start_size;
      bit hit;
      span       = search_span();
      repl       = (cfg_replace_len > 8) ? 8 : cfg_replace_len;
      start_size = rewritten_q.size();
      if (window_fill > 7) window_fill = 7;
      window[window_fill] = ch;
      window_fill++;
      if (window_fill >= span) begin
         hit = 1'b1;
         for (i = 0; i < span; i++)
            if (window[i] != cfg_search[8*i +: 8]) hit = 1'b0;
         if (hit) begin
            for (i = 0; i < repl; i++) expect_beat(cfg_replace[8*i +: 8], 1'b1);
            window_fill = 0;
         end else begin
            expect_beat(window[0], 1'b1);
            for (i = 0; i < 7; i++) window[i] = window[i+1];
            window_fill--;
         end
      end
      if (last) begin
         for (i = 0; i < window_fill; i++) expect_beat(window[i], 1'b1);
         window_fill = 0;
         // nothing left to carry the end mark: bare marker beat
         if (rewritten_q.size() == start_size) expect_beat('0, 1'b0);
         rewritten_q[rewritten_q.size()-1].last = 1'b1;
      end
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int pick_search_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
      return $urandom_range(0, 15);
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch @%0t: %s", $time, what);
   endtask

   // watch both streams and the register port at every edge
   always @(posedge clock) begin
      res_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               REG_SEARCH_TEXT:    cfg_search = csr_wdata;
               REG_SEARCH_LENGTH: begin
                  cfg_search_len = csr_wdata[LEN_W-1:0];
                  window_fill    = 0;
               end
               REG_REPLACE_TEXT:   cfg_replace = csr_wdata;
               REG_REPLACE_LENGTH: cfg_replace_len = csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_rewrite(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (rewritten_q.size() == 0) begin
               report_mismatch($sformatf("unexpected beat tdata %h tuser %b tlast %b",
                                         rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               want = rewritten_q.pop_front();
               if (rsp_tdata !== want.ch)
                  report_mismatch($sformatf("out_char got %h want %h", rsp_tdata, want.ch));
               if (rsp_tuser !== want.valid)
                  report_mismatch($sformatf("char_valid got %b want %b", rsp_tuser, want.valid));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("out_last got %b want %b", rsp_tlast, want.last));
            end
         end
      end
   end

   // result side: long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = gap_len() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // offer one byte, maybe after a gap, and return at the edge it is taken
   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
      int gap;
      gap = (gaps_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      chars_sent++;
   endtask

   task automatic send_text(input char_seq_type text);
      int k;
      for (k = 0; k < text.size(); k++) send_char(text[k], k == text.size() - 1);
   endtask

   // stop offering, wait for every owed beat, then let the block settle
   task automatic wait_drained();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (rewritten_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (rewritten_q.size() != 0) begin
         report_mismatch($sformatf("%0d expected beats never arrived", rewritten_q.size()));
         rewritten_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TEXT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // strings are given with the first character in the low byte
   task automatic configure(input logic [TEXT_W-1:0] search, input int slen,
                            input logic [TEXT_W-1:0] replace, input int rlen);
      write_reg(REG_SEARCH_TEXT, search);
      write_reg(REG_SEARCH_LENGTH, TEXT_W'(slen));
      write_reg(REG_REPLACE_TEXT, replace);
      write_reg(REG_REPLACE_LENGTH, TEXT_W'(rlen));
   endtask

   // reset search string is one NUL, replacement empty: NUL bytes vanish
   task automatic test_reset_defaults();
      send_text('{"a", 8'h00, "b"});
      wait_drained();
      // a lone NUL as the whole text leaves only the end marker
      send_text('{8'h00});
      wait_drained();
   endtask

   // "ab" -> "XYZ", with a partial window flushed at the end
   task automatic test_match_and_flush();
      configure("ba", 2, "ZYX", 3);
      send_text('{"x", 8'hff, "a", "b", "a", "b", "a"});
      wait_drained();
   endtask

   // match on the last byte with an empty replacement
   task automatic test_empty_tail();
      configure("dc", 2, '0, 0);
      send_text('{"c", "c", "d"});
      wait_drained();
   endtask

   // search length zero and fifteen, replace length fifteen
   task automatic test_length_limits();
      char_seq_type text;
      configure("q", 0, '1, 15);
      send_text('{"q"});
      wait_drained();
      configure('1, 15, "HGFEDCBA", 8);
      repeat (8) text.push_back(8'hff);
      send_text(text);
      wait_drained();
   endtask

   // rewriting search_length inside a text drops the pending byte
   task automatic test_length_write_mid_text();
      configure("ba", 2, "Z", 1);
      send_char("x", 1'b0);
      send_char("a", 1'b0);
      wait_drained();
      write_reg(REG_SEARCH_LENGTH, TEXT_W'(2));
      send_char("b", 1'b0);
      send_char("y", 1'b1);
      wait_drained();
   endtask

   // each 'a' expands to eight beats while the result side holds off
   task automatic test_backpressure();
      int k;
      configure("a", 1, "HGFEDCBA", 8);
      gaps_on      = 1'b0;
      hold_request = 1'b1;
      for (k = 0; k < 24; k++) send_char((k % 3 == 2) ? "b" : "a", k == 23);
      wait_drained();
      gaps_on = 1'b1;
   endtask

   // texts built mostly from pieces of the search string, some noise
   task automatic test_random_texts();
      char_seq_type text;
      logic [TEXT_W-1:0] pattern;
      int start_count, len, cut, span, piece, r, k;
      start_count = chars_sent;
      while (chars_sent < start_count + RANDOM_CHARS) begin
         if ($urandom_range(0, 2) == 0) begin
            pattern = {$urandom, $urandom};
            // small alphabet half the time so texts keep hitting it
            if ($urandom_range(0, 1) == 1)
               for (k = 0; k < 8; k++)
                  pattern[8*k +: 8] = CHAR_W'("a" + $urandom_range(0, 2));
            configure(pattern, pick_search_len(), {$urandom, $urandom},
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3));
         end
         gaps_on = ($urandom_range(0, 3) != 0);
         len     = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
         span    = search_span();
         text.delete();
         while (text.size() < len) begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
               // whole search string, or a broken prefix of it
               piece = (r == 0) ? $urandom_range(1, span) : span;
               for (k = 0; k < piece && text.size() < len; k++)
                  text.push_back(cfg_search[8*k +: 8]);
            end else if (r < 6) begin
               text.push_back(cfg_search[8*$urandom_range(0, span - 1) +: 8]);
            end else if (r < 8) begin
               text.push_back(CHAR_W'("a" + $urandom_range(0, 2)));
            end else begin
               text.push_back(CHAR_W'($urandom_range(0, 255)));
            end
         end
         cut = ($urandom_range(0, 9) == 0 && len > 1) ? $urandom_range(1, len - 1) : 0;
         for (k = 0; k < len; k++) begin
            if (cut != 0 && k == cut) begin
               wait_drained();
               write_reg(REG_SEARCH_LENGTH, TEXT_W'(pick_search_len()));
            end
            send_char(text[k], k == len - 1);
         end
         wait_drained();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_match_and_flush();
      test_empty_tail();
      test_length_limits();
      test_length_write_mid_text();
      test_backpressure();
      test_random_texts();
      wait_drained();
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
